// File: rtl/core/ftpu_pkg.sv
// shared types and constants of the ftp url field parser
package ftpu_pkg;

  localparam int unsigned FIELD_LEN = 32;
  localparam int unsigned IDX_W = $clog2(FIELD_LEN);
  localparam int unsigned CNT_W = $clog2(FIELD_LEN + 1);

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [1:0] KIND_USER = 2'd0;
  localparam logic [1:0] KIND_PASS = 2'd1;
  localparam logic [1:0] KIND_HOST = 2'd2;
  localparam logic [1:0] KIND_PATH = 2'd3;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_BAD_PREFIX = 2'd1;
  localparam logic [1:0] STAT_INCOMPLETE = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW   = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_STORE,
    OP_EMIT,
    OP_FLUSH
  } op_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] field_kind;
    logic       is_summary;
    logic [1:0] status;
    logic       anonymous_login;
    logic [5:0] path_length;
    logic [5:0] filename_start;
    logic       out_last;
  } out_t;

  typedef struct packed {
    op_e              op;
    logic [7:0]       ch;
    logic [1:0]       kind;
    logic [CNT_W-1:0] cnt;
    logic             sum;
    logic [1:0]       status;
    logic             anon;
    logic [5:0]       plen;
    logic [5:0]       fstart;
  } cmd_t;

endpackage

// File: rtl/core/ftpu_front.sv
// front end: prefix check, field classification and command generation
module ftpu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ftpu_pkg::in_t in_data_i,
  output logic          push_o,
  output ftpu_pkg::cmd_t cmd_o,
  input  logic          full_i
);

  localparam logic [2:0] MODE_PREFIX = 3'd0;
  localparam logic [2:0] MODE_USER   = 3'd1;
  localparam logic [2:0] MODE_PASS   = 3'd2;
  localparam logic [2:0] MODE_HOST   = 3'd3;
  localparam logic [2:0] MODE_PATH   = 3'd4;
  localparam logic [2:0] MODE_BAD    = 3'd5;

  localparam logic [2:0] PFX_LAST = 3'd5;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_AT    = 8'h40;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam logic [7:0] SCHEME [6] = '{8'h66, 8'h74, 8'h70, 8'h3A, 8'h2F, 8'h2F};

  localparam logic [ftpu_pkg::CNT_W-1:0] FULL_CNT =
    ftpu_pkg::CNT_W'(ftpu_pkg::FIELD_LEN);

  logic [2:0]                 mode_q, mode_d;
  logic [2:0]                 pfx_q, pfx_d;
  logic [ftpu_pkg::CNT_W-1:0] fidx_q, fidx_d;
  logic [ftpu_pkg::CNT_W-1:0] pcnt_q, pcnt_d;
  logic [ftpu_pkg::CNT_W-1:0] slash_q, slash_d;
  logic                       anon_q, anon_d;
  logic                       ovf_q, ovf_d;
  logic                       accept;
  ftpu_pkg::cmd_t             cmd;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    mode_d  = mode_q;
    pfx_d   = pfx_q;
    fidx_d  = fidx_q;
    pcnt_d  = pcnt_q;
    slash_d = slash_q;
    anon_d  = anon_q;
    ovf_d   = ovf_q;
    cmd        = '0;
    cmd.op     = ftpu_pkg::OP_NONE;
    cmd.ch     = in_data_i.in_char;
    cmd.kind   = ftpu_pkg::KIND_USER;
    cmd.status = ftpu_pkg::STAT_OK;

    unique case (mode_q)
      MODE_PREFIX: begin
        if (in_data_i.in_char == SCHEME[pfx_q]) begin
          if (pfx_q == PFX_LAST) begin
            pfx_d  = '0;
            mode_d = MODE_USER;
            fidx_d = '0;
          end else begin
            pfx_d = pfx_q + 3'd1;
          end
        end else begin
          mode_d = MODE_BAD;
        end
      end
      MODE_USER: begin
        if (in_data_i.in_char == CHAR_COLON) begin
          cmd.op   = ftpu_pkg::OP_FLUSH;
          cmd.kind = ftpu_pkg::KIND_USER;
          cmd.cnt  = fidx_q;
          fidx_d   = '0;
          mode_d   = MODE_PASS;
        end else if (in_data_i.in_char == CHAR_SLASH) begin
          cmd.op   = ftpu_pkg::OP_FLUSH;
          cmd.kind = ftpu_pkg::KIND_HOST;
          cmd.cnt  = fidx_q;
          fidx_d   = '0;
          anon_d   = 1'b1;
          mode_d   = MODE_PATH;
        end else if (fidx_q < FULL_CNT) begin
          cmd.op  = ftpu_pkg::OP_STORE;
          cmd.cnt = fidx_q;
          fidx_d  = fidx_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
      end
      MODE_PASS: begin
        if (in_data_i.in_char == CHAR_AT) begin
          mode_d = MODE_HOST;
          fidx_d = '0;
        end else if (fidx_q < FULL_CNT) begin
          cmd.op   = ftpu_pkg::OP_EMIT;
          cmd.kind = ftpu_pkg::KIND_PASS;
          fidx_d   = fidx_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
      end
      MODE_HOST: begin
        if (in_data_i.in_char == CHAR_SLASH) begin
          mode_d = MODE_PATH;
          fidx_d = '0;
        end else if (fidx_q < FULL_CNT) begin
          cmd.op   = ftpu_pkg::OP_EMIT;
          cmd.kind = ftpu_pkg::KIND_HOST;
          fidx_d   = fidx_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
      end
      MODE_PATH: begin
        if (pcnt_q < FULL_CNT) begin
          pcnt_d   = pcnt_q + 1'b1;
          cmd.op   = ftpu_pkg::OP_EMIT;
          cmd.kind = ftpu_pkg::KIND_PATH;
          if (in_data_i.in_char == CHAR_SLASH) begin
            slash_d = pcnt_q + 1'b1;
          end
        end else begin
          ovf_d = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (in_data_i.in_last) begin
      cmd.sum  = 1'b1;
      cmd.anon = anon_d;
      if (mode_d == MODE_PREFIX || mode_d == MODE_BAD) begin
        cmd.status = ftpu_pkg::STAT_BAD_PREFIX;
      end else if (mode_d == MODE_USER || mode_d == MODE_PASS) begin
        cmd.status = ftpu_pkg::STAT_INCOMPLETE;
      end else begin
        cmd.status = ovf_d ? ftpu_pkg::STAT_OVERFLOW : ftpu_pkg::STAT_OK;
        cmd.plen   = 6'(pcnt_d);
        cmd.fstart = 6'(slash_d);
      end
      mode_d  = MODE_PREFIX;
      pfx_d   = '0;
      fidx_d  = '0;
      pcnt_d  = '0;
      slash_d = '0;
      anon_d  = 1'b0;
      ovf_d   = 1'b0;
    end
  end

  assign push_o = accept && (cmd.op != ftpu_pkg::OP_NONE || cmd.sum);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PREFIX;
      pfx_q   <= '0;
      fidx_q  <= '0;
      pcnt_q  <= '0;
      slash_q <= '0;
      anon_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      pfx_q   <= pfx_d;
      fidx_q  <= fidx_d;
      pcnt_q  <= pcnt_d;
      slash_q <= slash_d;
      anon_q  <= anon_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// File: rtl/core/ftpu_cmd_fifo.sv
// command queue between front end and back end
module ftpu_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ftpu_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ftpu_pkg::cmd_t head_o
);

  localparam logic [ftpu_pkg::FIFO_PTR_W:0] DEPTH_CNT =
    (ftpu_pkg::FIFO_PTR_W + 1)'(ftpu_pkg::FIFO_DEPTH);

  ftpu_pkg::cmd_t                  slot_q [ftpu_pkg::FIFO_DEPTH];
  logic [ftpu_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [ftpu_pkg::FIFO_PTR_W:0]   cnt_q;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == DEPTH_CNT);
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/ftpu_back.sv
// back end: user buffer, flush sequencer and output register
module ftpu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  ftpu_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ftpu_pkg::out_t out_data_o
);

  localparam logic [1:0] ST_CMD   = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_SUM   = 2'd2;

  logic [7:0]                 ubuf [ftpu_pkg::FIELD_LEN];
  logic [7:0]                 rdata_q;
  logic [1:0]                 st_q, st_d;
  logic [ftpu_pkg::CNT_W-1:0] idx_q, idx_d;
  logic                       dv_q, dv_d;
  logic                       out_valid_q, out_valid_d;
  ftpu_pkg::out_t             out_q, out_nxt;
  logic                       can_load, load, mem_we, issue, emit, fl_done;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    st_d    = st_q;
    idx_d   = idx_q;
    dv_d    = dv_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    mem_we  = 1'b0;
    issue   = 1'b0;
    emit    = 1'b0;
    fl_done = 1'b0;
    out_nxt = '0;

    unique case (st_q)
      ST_CMD: begin
        if (!empty_i) begin
          case (head_i.op)
            ftpu_pkg::OP_STORE: begin
              mem_we = 1'b1;
              if (head_i.sum) begin
                st_d = ST_SUM;
              end else begin
                pop_o = 1'b1;
              end
            end
            ftpu_pkg::OP_EMIT: begin
              if (can_load) begin
                load                = 1'b1;
                out_nxt.out_char    = head_i.ch;
                out_nxt.field_kind  = head_i.kind;
                out_nxt.out_last    = !head_i.sum;
                if (head_i.sum) begin
                  st_d = ST_SUM;
                end else begin
                  pop_o = 1'b1;
                end
              end
            end
            ftpu_pkg::OP_FLUSH: begin
              st_d  = ST_FLUSH;
              idx_d = '0;
              dv_d  = 1'b0;
            end
            default: begin
              st_d = ST_SUM;
            end
          endcase
        end
      end
      ST_FLUSH: begin
        emit    = dv_q && can_load;
        issue   = (idx_q != head_i.cnt) && (!dv_q || emit);
        fl_done = (idx_q == head_i.cnt) && (!dv_q || emit);
        if (emit) begin
          load               = 1'b1;
          out_nxt.out_char   = rdata_q;
          out_nxt.field_kind = head_i.kind;
          out_nxt.out_last   = (idx_q == head_i.cnt) && !head_i.sum;
        end
        if (issue) begin
          idx_d = idx_q + 1'b1;
          dv_d  = 1'b1;
        end else if (emit) begin
          dv_d = 1'b0;
        end
        if (fl_done) begin
          if (head_i.sum) begin
            st_d = ST_SUM;
          end else begin
            pop_o = 1'b1;
            st_d  = ST_CMD;
          end
        end
      end
      ST_SUM: begin
        if (can_load) begin
          load                    = 1'b1;
          out_nxt.is_summary      = 1'b1;
          out_nxt.status          = head_i.status;
          out_nxt.anonymous_login = head_i.anon;
          out_nxt.path_length     = head_i.plen;
          out_nxt.filename_start  = head_i.fstart;
          out_nxt.out_last        = 1'b1;
          pop_o                   = 1'b1;
          st_d                    = ST_CMD;
        end
      end
      default: begin
        st_d = ST_CMD;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ubuf[head_i.cnt[ftpu_pkg::IDX_W-1:0]] <= head_i.ch;
    end
    if (issue) begin
      rdata_q <= ubuf[idx_q[ftpu_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CMD;
      idx_q       <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      idx_q       <= idx_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/ftp_url_field_parser.sv
// top level of the ftp url field parser
//
// input channel: one url byte per transaction (in_valid_i / in_ready_o,
// payload in_data_i), in_last marks the final byte of a url.
// output channel: one field character or the end-of-url summary per
// transaction (out_valid_o / out_ready_i, payload out_data_o); out_last
// marks the final result caused by an input byte.
// a pass, host or path character goes through the command queue and
// then the output register; a summary also goes through the ST_SUM state.
// throughput: one byte per cycle while the command queue is not full; a
// ':' or '/' that releases n buffered user characters keeps the back end
// busy in its flush sequence, while the front end keeps taking bytes into
// its four-entry command queue. in_ready_o falls only when it is full.
// reset empties the queue and the output register and puts the parser
// back into the ftp:// prefix check.
// when the receiver stalls, the output register holds its transaction,
// the back end waits and the queue fills, then the input stalls.
module ftp_url_field_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ftpu_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ftpu_pkg::out_t out_data_o
);

  logic           push, full, pop, empty;
  ftpu_pkg::cmd_t cmd, head;

  ftpu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .cmd_o      (cmd),
    .full_i     (full)
  );

  ftpu_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  ftpu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/core/ftpu_checker.sv
// port-level checks of the ftp url field parser and their binding
module ftpu_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input ftpu_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input ftpu_pkg::out_t out_data_o
);

  localparam logic [5:0] MAX_LEN = 6'(ftpu_pkg::FIELD_LEN);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input transaction changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_summary |->
      out_data_o.out_last && out_data_o.out_char == 8'd0 &&
      out_data_o.field_kind == ftpu_pkg::KIND_USER)
    else $error("summary transaction malformed");

  a_char_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_summary |->
      out_data_o.status == ftpu_pkg::STAT_OK && !out_data_o.anonymous_login &&
      out_data_o.path_length == 6'd0 && out_data_o.filename_start == 6'd0)
    else $error("character transaction carries summary fields");

  a_sum_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_summary |->
      out_data_o.path_length <= MAX_LEN &&
      out_data_o.filename_start <= out_data_o.path_length)
    else $error("summary lengths out of range");

endmodule

bind ftp_url_field_parser ftpu_checker u_ftpu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
